>>> src/bmr8_pkg.sv
// Shared types and constants for the RLE8 pixel-stream decoder.
// Used by the front, the queue, the back, the geometry stage and the top level.
package bmr8_pkg;

    localparam int DIM_W       = 13;                  // column, row and image size
    localparam int POS_W       = 27;                  // linear pixel positions
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Second byte of an escape pair
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOI   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    // Commands from the front to the back
    typedef enum logic [2:0] {
        OP_START = 3'd0,   // new image: position back to the origin
        OP_RUN   = 3'd1,   // arg_a = pixel count, arg_b = color
        OP_EOL   = 3'd2,   // end of line
        OP_EOI   = 3'd3,   // end of bitmap
        OP_DELTA = 3'd4    // arg_a = columns, arg_b = rows
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] arg_a;
        logic [BYTE_W-1:0] arg_b;
    } t_cmd;

    // Effective image geometry after clamping
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [POS_W-1:0] total;
    } t_geom;

endpackage

>>> src/bmp_rle8_decoder_core.sv
// RLE8 decoder top level. A run or literal result passes through the command
// queue, the back end's run setup and its output register; bytes are taken
// one per cycle while the command queue has room. The back end handles each
// run or literal in idle and run states, plus wrap steps past two row ends.
// Reset is synchronous, active low: size registers to 1, position
// and parse phase cleared, queue emptied; no clearing pass.
module bmp_rle8_decoder_core import bmr8_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_code_byte,
    input  logic                 i_start_image,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [23:0]          o_pixel_index,
    output logic [BYTE_W-1:0]    o_run_length,
    output logic [BYTE_W-1:0]    o_pixel_value,
    output logic                 o_end_of_image,
    output logic                 o_out_of_range
);

    logic [DIM_W-1:0] r_cfg_width;
    logic [DIM_W-1:0] r_cfg_height;
    t_geom            geom;
    logic             q_push, q_pop, q_empty, q_full;
    t_cmd             push_cmd, head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_W'(1);
            r_cfg_height <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    bmr8_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_width  (r_cfg_width),
        .i_cfg_height (r_cfg_height),
        .o_geom       (geom)
    );

    bmr8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_code_byte   (i_code_byte),
        .i_start_image (i_start_image),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    bmr8_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bmr8_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_q_empty      (q_empty),
        .i_cmd          (head_cmd),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_index  (o_pixel_index),
        .o_run_length   (o_run_length),
        .o_pixel_value  (o_pixel_value),
        .o_end_of_image (o_end_of_image),
        .o_out_of_range (o_out_of_range)
    );

endmodule

>>> src/bmr8_front.sv
// Front end: takes stream bytes, tracks the RLE8 parse phase and
// turns each byte into at most one command. Depends on bmr8_pkg.
module bmr8_front import bmr8_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_code_byte,
    input  logic              i_start_image,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    typedef enum logic [6:0] {
        PH_COUNT   = 7'b0000001,
        PH_SECOND  = 7'b0000010,
        PH_DELTA_X = 7'b0000100,
        PH_DELTA_Y = 7'b0001000,
        PH_LITERAL = 7'b0010000,
        PH_PAD     = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    t_phase            r_phase, n_phase, e_phase;
    logic [BYTE_W-1:0] r_first, n_first, e_first;
    logic [BYTE_W-1:0] r_left,  n_left,  e_left;
    logic              r_pad,   n_pad,   e_pad;
    logic [BYTE_W-1:0] r_dx,    n_dx,    e_dx;
    logic              accept;
    logic              cmd_v;
    t_cmd              cmd;

    always_comb begin
        accept  = i_in_valid && !i_q_full;
        // start of image clears the parse state before the byte is taken
        e_phase = i_start_image ? PH_COUNT : r_phase;
        e_first = i_start_image ? '0 : r_first;
        e_left  = i_start_image ? '0 : r_left;
        e_pad   = i_start_image ? 1'b0 : r_pad;
        e_dx    = i_start_image ? '0 : r_dx;

        n_phase   = e_phase;
        n_first   = e_first;
        n_left    = e_left;
        n_pad     = e_pad;
        n_dx      = e_dx;
        cmd_v     = i_start_image;
        cmd.op    = OP_START;
        cmd.arg_a = e_first;
        cmd.arg_b = i_code_byte;

        unique case (e_phase)
            PH_COUNT: begin
                n_first = i_code_byte;
                n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                n_phase = PH_COUNT;
                if (e_first != '0) begin
                    cmd_v  = 1'b1;
                    cmd.op = OP_RUN;
                end else if (i_code_byte == ESC_EOL) begin
                    cmd_v  = 1'b1;
                    cmd.op = OP_EOL;
                end else if (i_code_byte == ESC_EOI) begin
                    cmd_v   = 1'b1;
                    cmd.op  = OP_EOI;
                    n_phase = PH_DONE;
                end else if (i_code_byte == ESC_DELTA) begin
                    n_phase = PH_DELTA_X;
                end else begin
                    n_left  = i_code_byte;
                    n_pad   = i_code_byte[0];
                    n_phase = PH_LITERAL;
                end
            end
            PH_DELTA_X: begin
                n_dx    = i_code_byte;
                n_phase = PH_DELTA_Y;
            end
            PH_DELTA_Y: begin
                cmd_v     = 1'b1;
                cmd.op    = OP_DELTA;
                cmd.arg_a = e_dx;
                n_phase   = PH_COUNT;
            end
            PH_LITERAL: begin
                cmd_v     = 1'b1;
                cmd.op    = OP_RUN;
                cmd.arg_a = 8'd1;
                n_left    = (e_left != '0) ? e_left - 8'd1 : '0;
                if (n_left == '0) begin
                    n_phase = e_pad ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD: begin
                n_pad   = 1'b0;
                n_phase = PH_COUNT;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_first <= '0;
            r_left  <= '0;
            r_pad   <= 1'b0;
            r_dx    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_left  <= n_left;
            r_pad   <= n_pad;
            r_dx    <= n_dx;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = accept && cmd_v;
    assign o_cmd      = cmd;

endmodule

>>> src/bmr8_cmd_fifo.sv
// Short command queue between the front and the back.
// Register based, one read port at the head. Depends on bmr8_pkg.
module bmr8_cmd_fifo import bmr8_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty command queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (QPTR_W+1)'(1)))
        else $error("queue count lost a push");

endmodule

>>> src/bmr8_back.sv
// Back end: owns column and row, executes queued commands and
// produces run writes through an output register. Depends on bmr8_pkg.
module bmr8_back import bmr8_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic               i_q_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [23:0]        o_pixel_index,
    output logic [BYTE_W-1:0]  o_run_length,
    output logic [BYTE_W-1:0]  o_pixel_value,
    output logic               o_end_of_image,
    output logic               o_out_of_range
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WRAP = 4'b0100,
        S_EOI  = 4'b1000
    } t_state;

    // row counter saturates at all ones
    function automatic logic [DIM_W-1:0] row_add(input logic [DIM_W-1:0] r,
                                                 input logic [BYTE_W-1:0] a);
        logic [DIM_W:0] s;
        s = {1'b0, r} + (DIM_W+1)'(a);
        return s[DIM_W] ? '1 : s[DIM_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_col, n_col;
    logic [DIM_W-1:0]   r_row, n_row;
    logic [POS_W-1:0]   r_p, n_p;
    logic [DIM_W:0]     r_colsum, n_colsum;
    logic [BYTE_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0]  r_color, n_color;
    logic               r_out_valid, n_out_valid;
    logic [23:0]        r_idx, n_idx;
    logic [BYTE_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0]  r_val, n_val;
    logic               r_eoi, n_eoi;
    logic               r_oor, n_oor;

    logic               out_free;
    logic               load;
    logic               wrap_step;
    logic               col_wrap;
    logic [DIM_W-1:0]   col0, row0;
    logic [2*DIM_W-1:0] prod;
    logic [DIM_W-1:0]   dcol, drow;
    logic [POS_W-1:0]   p_end, rem;
    logic [DIM_W:0]     width_x, sub1, sub2;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        width_x  = {1'b0, i_geom.width};

        // column past the row moves to the start of the next row
        col_wrap = (r_col >= i_geom.width);
        col0     = col_wrap ? '0 : r_col;
        row0     = col_wrap ? row_add(r_row, 8'd1) : r_row;
        prod     = row0 * i_geom.width;

        dcol = r_col + DIM_W'(i_cmd.arg_a);
        drow = row_add(r_row, i_cmd.arg_b);
        if (dcol >= i_geom.width) begin
            dcol = '0;
            drow = row_add(drow, 8'd1);
        end

        p_end = r_p + POS_W'(r_count);
        rem   = i_geom.total - r_p;
        sub1  = r_colsum - width_x;
        sub2  = sub1 - width_x;

        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_p         = r_p;
        n_colsum    = r_colsum;
        n_count     = r_count;
        n_color     = r_color;
        n_idx       = r_idx;
        n_len       = r_len;
        n_val       = r_val;
        n_eoi       = r_eoi;
        n_oor       = r_oor;
        o_pop       = 1'b0;
        load        = 1'b0;
        wrap_step   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_START: begin
                            n_col = '0;
                            n_row = '0;
                        end
                        OP_EOL: begin
                            n_col = '0;
                            n_row = row_add(r_row, 8'd1);
                        end
                        OP_DELTA: begin
                            n_col = dcol;
                            n_row = drow;
                        end
                        OP_RUN: begin
                            n_row    = row0;
                            n_p      = POS_W'(prod) + POS_W'(col0);
                            n_colsum = {1'b0, col0} + (DIM_W+1)'(i_cmd.arg_a);
                            n_count  = i_cmd.arg_a;
                            n_color  = i_cmd.arg_b;
                            n_state  = S_RUN;
                        end
                        OP_EOI: begin
                            n_state = S_EOI;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (out_free) begin
                    load      = 1'b1;
                    wrap_step = 1'b1;
                    n_val     = r_color;
                    n_eoi     = 1'b0;
                    if (r_p >= i_geom.total) begin
                        n_idx = '0;
                        n_len = '0;
                        n_oor = 1'b1;
                    end else if (p_end > i_geom.total) begin
                        n_idx = r_p[23:0];
                        n_len = rem[BYTE_W-1:0];
                        n_oor = 1'b1;
                    end else begin
                        n_idx = r_p[23:0];
                        n_len = r_count;
                        n_oor = 1'b0;
                    end
                end
            end
            S_WRAP: begin
                wrap_step = 1'b1;
            end
            S_EOI: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_idx   = '0;
                    n_len   = '0;
                    n_val   = '0;
                    n_eoi   = 1'b1;
                    n_oor   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance the position past the run, up to two row crossings a cycle
        if (wrap_step) begin
            if (r_colsum < width_x) begin
                n_col   = r_colsum[DIM_W-1:0];
                n_state = S_IDLE;
            end else if (sub1 < width_x) begin
                n_col   = sub1[DIM_W-1:0];
                n_row   = row_add(r_row, 8'd1);
                n_state = S_IDLE;
            end else begin
                n_colsum = sub2;
                n_row    = row_add(r_row, 8'd2);
                n_state  = S_WRAP;
            end
        end

        n_out_valid = (r_out_valid && i_out_stall) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_colsum <= n_colsum;
        r_count  <= n_count;
        r_color  <= n_color;
        r_idx    <= n_idx;
        r_len    <= n_len;
        r_val    <= n_val;
        r_eoi    <= n_eoi;
        r_oor    <= n_oor;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_index  = r_idx;
    assign o_run_length   = r_len;
    assign o_pixel_value  = r_val;
    assign o_end_of_image = r_eoi;
    assign o_out_of_range = r_oor;

    a_eoi_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eoi) |->
            (r_len == '0 && r_idx == '0 && r_val == '0 && !r_oor))
        else $error("malformed end-of-bitmap result");

    a_unclipped_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_eoi && !r_oor) |-> (r_len != '0))
        else $error("in-range run with zero length");

    a_wrap_row_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |=> (r_row >= $past(r_row)))
        else $error("row moved backward during run wrap");

endmodule

>>> src/bmr8_decoder_core_stub.sv
// Geometry stage: clamps the configured image size and forms the pixel
// total for the back end. Depends on bmr8_pkg.
module bmr8_geom import bmr8_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_cfg_width,
    input  logic [DIM_W-1:0] i_cfg_height,
    output t_geom            o_geom
);

    logic [DIM_W-1:0]   r_width_eff, n_width_eff;
    logic [DIM_W-1:0]   r_height_eff, n_height_eff;
    logic [POS_W-1:0]   r_total;
    logic [2*DIM_W-1:0] prod;

    always_comb begin
        if (i_cfg_width == '0) begin
            n_width_eff = DIM_W'(1);
        end else if (32'(i_cfg_width) > 32'(MAX_WIDTH)) begin
            n_width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            n_width_eff = i_cfg_width;
        end
        if (i_cfg_height == '0) begin
            n_height_eff = DIM_W'(1);
        end else if (32'(i_cfg_height) > 32'(MAX_HEIGHT)) begin
            n_height_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            n_height_eff = i_cfg_height;
        end
        prod = r_width_eff * r_height_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_eff  <= DIM_W'(1);
            r_height_eff <= DIM_W'(1);
            r_total      <= POS_W'(1);
        end else begin
            r_width_eff  <= n_width_eff;
            r_height_eff <= n_height_eff;
            r_total      <= POS_W'(prod);
        end
    end

    assign o_geom.width = r_width_eff;
    assign o_geom.total = r_total;

endmodule
